>>> hdl/masked_color_substitution_defines.svh
// ----------------------------------------------------------------------------
// masked color substitution assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MASKED_COLOR_SUBSTITUTION_DEFINES_SVH
`define MASKED_COLOR_SUBSTITUTION_DEFINES_SVH

// same-cycle implication
`define MCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types, codes and constants of the masked color substitution block
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 8;

    localparam logic [31:0] MASK_RESET = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_SUBST = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] color_in;
        logic [31:0] new_color;
    } req_t;

    typedef struct packed {
        logic [31:0] color_out;
        logic        matched;
        logic        table_full;
    } rsp_t;

    typedef struct packed {
        logic load_item;
        logic idx_inc;
        logic write_repl;
        logic append;
        logic clear_table;
        logic res_pass;
        logic res_merge;
        logic res_hit;
        logic res_full;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       count_zero;
        logic       at_last;
        logic       has_room;
        logic       masked_hit;
        logic       exact_hit;
    } status_t;

endpackage

>>> hdl/mcs_datapath.sv
// ----------------------------------------------------------------------------
// mcs_datapath
// mask register, key and replacement memories, scan index, entry count,
// compare logic and result registers
// ----------------------------------------------------------------------------
module mcs_datapath #(
    parameter int TABLE_DEPTH = mcs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_data,
    input  mcs_pkg::req_t  req_data,
    input  mcs_pkg::cmd_t  cmd,
    output mcs_pkg::status_t status,
    output mcs_pkg::rsp_t  rsp_data
);
    import mcs_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] repl_mem [TABLE_DEPTH];

    logic [31:0]      mask_reg;
    req_t             item_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      key_rd_reg;
    logic [31:0]      repl_rd_reg;
    rsp_t             res_reg;
    rsp_t             out_reg;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      merged;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_item)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_table)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= MASK_RESET;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_data;
            end
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // table memories
    assign wr_addr = cmd.append ? count_reg[IDX_W-1:0] : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            key_mem[wr_addr] <= item_reg.color_in;
        end
        if (cmd.append || cmd.write_repl)
        begin
            repl_mem[wr_addr] <= item_reg.new_color;
        end
        key_rd_reg  <= key_mem[idx_reg];
        repl_rd_reg <= repl_mem[idx_reg];
    end

    assign merged = (repl_rd_reg & mask_reg) | (item_reg.color_in & ~mask_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req_data;
            res_reg  <= '0;
        end
        else
        begin
            if (cmd.res_pass)
            begin
                res_reg.color_out <= item_reg.color_in;
            end
            if (cmd.res_merge)
            begin
                res_reg.color_out <= merged;
                res_reg.matched   <= 1'b1;
            end
            if (cmd.res_hit)
            begin
                res_reg.matched <= 1'b1;
            end
            if (cmd.res_full)
            begin
                res_reg.table_full <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign status.action     = item_reg.action;
    assign status.count_zero = (count_reg == '0);
    assign status.at_last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign status.has_room   = (count_reg < CNT_W'(TABLE_DEPTH));
    assign status.masked_hit = (((item_reg.color_in ^ key_rd_reg) & mask_reg) == 32'd0);
    assign status.exact_hit  = (item_reg.color_in == key_rd_reg);

    assign rsp_data = out_reg;

endmodule

>>> hdl/mcs_controller.sv
// ----------------------------------------------------------------------------
// mcs_controller
// sequencer for one item: dispatch, entry scan, result hand-off
// ----------------------------------------------------------------------------
module mcs_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  mcs_pkg::status_t  status,
    output mcs_pkg::cmd_t     cmd
);
    import mcs_pkg::*;

    `include "masked_color_substitution_defines.svh"

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DISPATCH = 5'b00010,
        ST_READ     = 5'b00100,
        ST_CHECK    = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   req_accept;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_FINISH;
                case (status.action)
                    ACT_SUBST:
                    begin
                        if (status.count_zero)
                        begin
                            cmd.res_pass = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (status.count_zero)
                        begin
                            cmd.append = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear_table = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
                if (status.action == ACT_SUBST)
                begin
                    if (status.masked_hit)
                    begin
                        cmd.res_merge = 1'b1;
                    end
                    else if (status.at_last)
                    begin
                        cmd.res_pass = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
                else
                begin
                    if (status.exact_hit)
                    begin
                        cmd.write_repl = 1'b1;
                        cmd.res_hit    = 1'b1;
                    end
                    else if (status.at_last)
                    begin
                        if (status.has_room)
                        begin
                            cmd.append = 1'b1;
                        end
                        else
                        begin
                            cmd.res_full = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && rsp_stall) || cmd.load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MCS_ASSERT_NEXT(a_accept_dispatch, req_accept, state_reg == ST_DISPATCH)
    `MCS_ASSERT_IMPL(a_append_room, cmd.append, status.has_room)
    `MCS_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_valid_reg || !rsp_stall)
    `MCS_ASSERT_IMPL(a_update_hit, cmd.write_repl, status.exact_hit && status.action == ACT_ADD)

endmodule

>>> hdl/masked_color_substitution.sv
// ----------------------------------------------------------------------------
// masked_color_substitution
// key/replacement color table with masked first-match pixel substitution
// ----------------------------------------------------------------------------
//  channel | signals                       | direction
//  req     | req_valid req_stall req_data  | item in: action, color_in, new_color
//  rsp     | rsp_valid rsp_stall rsp_data  | beat out: color_out, matched, table_full
//  cfg     | cfg_we cfg_data               | compare mask write
//
//  one item at a time; the entries are scanned in order, at most the entry
//  count of them, each with a registered table read and then a compare
//  a new item is accepted while the previous beat waits on rsp_stall
//  reset clears the entry count and sets the mask to all ones
// ----------------------------------------------------------------------------
module masked_color_substitution #(
    parameter int TABLE_DEPTH = mcs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mcs_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mcs_pkg::rsp_t rsp_data,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_data
);
    import mcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    mcs_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mcs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req_data (req_data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule
